// File: rtl/core/bbs_pkg.sv
// ----------------------------------------------------------------------------
// Beam-break ball sensor package
// Types and constants shared by the ball sensor modules.
// ----------------------------------------------------------------------------
package bbs_pkg;

   localparam int SampleWidth = 10;
   localparam int RunWidth    = 8;
   localparam int CsrAddrWidth = 4;
   localparam int CsrDataWidth = 32;

   localparam logic [SampleWidth-1:0] FULL_SCALE = 10'h3ff;

   localparam logic [SampleWidth-1:0] DAZZLE_LIMIT_RESET = 10'd500;
   localparam logic [SampleWidth-1:0] BEAM_MARGIN_RESET  = 10'd500;
   localparam logic [RunWidth-1:0]    OPEN_RUN_RESET     = 8'd100;
   localparam logic [SampleWidth-1:0] OPEN_LEVEL_RESET   = 10'd3;

   typedef enum logic [1:0] {
      REG_DAZZLE_LIMIT = 2'd0,
      REG_BEAM_MARGIN  = 2'd1,
      REG_OPEN_RUN     = 2'd2,
      REG_OPEN_LEVEL   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [SampleWidth-1:0] adc_sample;
      logic                   emitter_pin_high;
   } req_type;

   typedef struct packed {
      logic ball_present;
      logic emitter_drive;
      logic fault_emitter_open;
      logic fault_detector_open;
      logic fault_detector_short;
      logic fault_dazzled;
   } rsp_type;

   typedef struct packed {
      logic [SampleWidth-1:0] dazzle_limit;
      logic [SampleWidth-1:0] beam_margin;
      logic [RunWidth-1:0]    open_run_length;
      logic [SampleWidth-1:0] open_level;
   } cfg_type;

endpackage

// File: rtl/core/bbs_csr.sv
// ----------------------------------------------------------------------------
// Beam-break ball sensor configuration registers
// APB-style register file holding the thresholds and the open-run length.
// ----------------------------------------------------------------------------
module bbs_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bbs_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [bbs_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [bbs_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                               csr_pready,
   output bbs_pkg::cfg_type                   cfg
);
   import bbs_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_en;
   reg_index_type wr_index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign wr_index   = reg_index_type'(csr_paddr[CsrAddrWidth-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            REG_DAZZLE_LIMIT: cfg_in.dazzle_limit    = csr_pwdata[SampleWidth-1:0];
            REG_BEAM_MARGIN:  cfg_in.beam_margin     = csr_pwdata[SampleWidth-1:0];
            REG_OPEN_RUN:     cfg_in.open_run_length = csr_pwdata[RunWidth-1:0];
            REG_OPEN_LEVEL:   cfg_in.open_level      = csr_pwdata[SampleWidth-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (wr_index)
         REG_DAZZLE_LIMIT: csr_prdata[SampleWidth-1:0] = cfg_ff.dazzle_limit;
         REG_BEAM_MARGIN:  csr_prdata[SampleWidth-1:0] = cfg_ff.beam_margin;
         REG_OPEN_RUN:     csr_prdata[RunWidth-1:0]    = cfg_ff.open_run_length;
         REG_OPEN_LEVEL:   csr_prdata[SampleWidth-1:0] = cfg_ff.open_level;
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dazzle_limit    <= DAZZLE_LIMIT_RESET;
         cfg_ff.beam_margin     <= BEAM_MARGIN_RESET;
         cfg_ff.open_run_length <= OPEN_RUN_RESET;
         cfg_ff.open_level      <= OPEN_LEVEL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/bbs_core.sv
// ----------------------------------------------------------------------------
// Beam-break ball sensor core
// Per-tick sensor state update with a registered result stage.
// ----------------------------------------------------------------------------
module bbs_core (
   input  logic              clock,
   input  logic              reset,
   input  bbs_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  bbs_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bbs_pkg::rsp_type  rsp_data
);
   import bbs_pkg::*;

   logic                   skip_ff, skip_in;
   logic                   emit_on_ff, emit_on_in;
   logic [SampleWidth-1:0] light_ff, light_in;
   logic [SampleWidth-1:0] dark_ff, dark_in;
   logic [RunWidth-1:0]    run_cnt_ff, run_cnt_in;
   logic                   f_emit_ff, f_emit_in;
   logic                   f_open_ff, f_open_in;
   logic                   f_short_ff, f_short_in;
   logic                   f_dazzle_ff, f_dazzle_in;
   logic                   ball_ff, ball_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic [SampleWidth-1:0] inv_sample;
   logic                   near_zero;
   logic signed [SampleWidth:0] diff;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign accept     = req_valid & ~req_stall;
   assign inv_sample = FULL_SCALE - req_data.adc_sample;

   always_comb begin
      skip_in     = skip_ff;
      emit_on_in  = emit_on_ff;
      light_in    = light_ff;
      dark_in     = dark_ff;
      run_cnt_in  = run_cnt_ff;
      f_emit_in   = f_emit_ff;
      f_open_in   = f_open_ff;
      f_short_in  = f_short_ff;
      f_dazzle_in = f_dazzle_ff;
      ball_in     = ball_ff;
      near_zero   = 1'b0;
      diff        = '0;

      if (accept) begin
         skip_in = ~skip_ff;
         if (skip_ff) begin
            if (emit_on_ff) begin
               light_in   = inv_sample;
               f_emit_in  = ~req_data.emitter_pin_high;
               emit_on_in = 1'b0;
            end else begin
               dark_in    = inv_sample;
               emit_on_in = 1'b1;
            end

            near_zero = (dark_in <= cfg.open_level) && (light_in <= cfg.open_level);
            f_open_in = 1'b0;
            if (near_zero) begin
               if (run_cnt_ff >= cfg.open_run_length) begin
                  f_open_in = 1'b1;
               end else begin
                  run_cnt_in = run_cnt_ff + 1'b1;
               end
            end else begin
               run_cnt_in = '0;
            end

            f_short_in  = (dark_in == FULL_SCALE) && (light_in == FULL_SCALE);
            f_dazzle_in = ~f_short_in && (dark_in > cfg.dazzle_limit);

            diff = $signed({1'b0, light_in}) - $signed({1'b0, dark_in});
            if (f_emit_in | f_open_in | f_short_in | f_dazzle_in) begin
               ball_in = 1'b0;
            end else begin
               ball_in = diff < $signed({1'b0, cfg.beam_margin});
            end
         end
      end
   end

   always_comb begin
      rsp_data_in.ball_present         = ball_in;
      rsp_data_in.emitter_drive        = emit_on_in;
      rsp_data_in.fault_emitter_open   = f_emit_in;
      rsp_data_in.fault_detector_open  = f_open_in;
      rsp_data_in.fault_detector_short = f_short_in;
      rsp_data_in.fault_dazzled        = f_dazzle_in;
      rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff      <= 1'b0;
         emit_on_ff   <= 1'b0;
         light_ff     <= '0;
         dark_ff      <= '0;
         run_cnt_ff   <= '0;
         f_emit_ff    <= 1'b0;
         f_open_ff    <= 1'b0;
         f_short_ff   <= 1'b0;
         f_dazzle_ff  <= 1'b0;
         ball_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         skip_ff      <= skip_in;
         emit_on_ff   <= emit_on_in;
         light_ff     <= light_in;
         dark_ff      <= dark_in;
         run_cnt_ff   <= run_cnt_in;
         f_emit_ff    <= f_emit_in;
         f_open_ff    <= f_open_in;
         f_short_ff   <= f_short_in;
         f_dazzle_ff  <= f_dazzle_in;
         ball_ff      <= ball_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/core/beam_break_ball_sensor_unit.sv
// ----------------------------------------------------------------------------
// Beam-break ball sensor unit
// Each accepted beat's result is registered and presented in the next cycle.
// Throughput is one beat per cycle while the result side does not stall, set by the single result register.
// Synchronous active-high reset clears the sensor state and result valid,
// and loads the register defaults.
// ----------------------------------------------------------------------------
module beam_break_ball_sensor_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  bbs_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output bbs_pkg::rsp_type                  rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bbs_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [bbs_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [bbs_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import bbs_pkg::*;

   cfg_type cfg;

   bbs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bbs_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/core/bbs_checker.sv
// ----------------------------------------------------------------------------
// Beam-break ball sensor checker
// Port-level assertions for the ball sensor unit, bound to the top level.
// ----------------------------------------------------------------------------
module bbs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input bbs_pkg::rsp_type rsp_data
);
   import bbs_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled result beat changed.");

   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("Input taken while result beat is stalled.");

   a_ball_healthy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.ball_present |->
         !(rsp_data.fault_emitter_open || rsp_data.fault_detector_open ||
           rsp_data.fault_detector_short || rsp_data.fault_dazzled))
      else $error("Ball reported present with a fault set.");

   a_short_dazzle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.fault_detector_short && rsp_data.fault_dazzled))
      else $error("Short and dazzle faults set together.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result valid after reset.");

endmodule

bind beam_break_ball_sensor_unit bbs_checker u_bbs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: verif/tb_beam_break_ball_sensor_unit.sv
// ----------------------------------------------------------------------------
// Beam-break ball sensor unit testbench
// Drives control ticks into the sensor unit and checks every result beat
// against a cycle-free prediction of the sensor state. Covers directed tick
// sequences, register access, extreme register settings, the detector-open
// run counter, a long result-side hold and random traffic with random bursts
// and gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_beam_break_ball_sensor_unit;
   import bbs_pkg::*;

   localparam int CycleLimit  = 400000;
   localparam int ReportLimit = 10;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_stall;
   req_type                 req_data    = '0;
   logic                    rsp_valid;
   logic                    rsp_stall   = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr   = '0;
   logic [CsrDataWidth-1:0] csr_pwdata  = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   logic [SampleWidth-1:0]  dazzle_lim = DAZZLE_LIMIT_RESET;
   logic [SampleWidth-1:0]  margin_lim = BEAM_MARGIN_RESET;
   logic [RunWidth-1:0]     run_lim    = OPEN_RUN_RESET;
   logic [SampleWidth-1:0]  open_lvl   = OPEN_LEVEL_RESET;

   logic                    skip_phase = 1'b0;
   logic                    led_on     = 1'b0;
   logic [SampleWidth-1:0]  light_rd   = '0;
   logic [SampleWidth-1:0]  dark_rd    = '0;
   logic [RunWidth-1:0]     zero_run   = '0;
   logic                    f_emit     = 1'b0;
   logic                    f_open     = 1'b0;
   logic                    f_short    = 1'b0;
   logic                    f_dazzle   = 1'b0;
   logic                    ball       = 1'b0;

   rsp_type pending_reports[$];
   int      fail_count  = 0;
   int      cycle_count = 0;
   int      hold_left   = 0;
   int      stall_pct   = 0;
   int      max_gap     = 0;
   int      burst_left  = 0;

   always #2 clock = ~clock;

   beam_break_ball_sensor_unit i_dut (.*);

   function automatic rsp_type sensor_tick(input req_type beat);
      logic [SampleWidth-1:0] level;
      int                     diff;
      rsp_type                rep;
      level = FULL_SCALE - beat.adc_sample;
      skip_phase = ~skip_phase;
      if (!skip_phase) begin
         if (led_on) begin
            light_rd = level;
            f_emit = ~beat.emitter_pin_high;
            led_on = 1'b0;
         end else begin
            dark_rd = level;
            led_on = 1'b1;
         end
         f_open = 1'b0;
         f_short = 1'b0;
         f_dazzle = 1'b0;
         if (dark_rd <= open_lvl && light_rd <= open_lvl) begin
            if (zero_run >= run_lim) f_open = 1'b1;
            else zero_run = zero_run + 1'b1;
         end else begin
            zero_run = '0;
         end
         if (dark_rd == FULL_SCALE && light_rd == FULL_SCALE) f_short = 1'b1;
         else if (dark_rd > dazzle_lim) f_dazzle = 1'b1;
         diff = int'(light_rd) - int'(dark_rd);
         ball = !(f_emit || f_open || f_short || f_dazzle) && (diff < int'(margin_lim));
      end
      rep.ball_present = ball;
      rep.emitter_drive = led_on;
      rep.fault_emitter_open = f_emit;
      rep.fault_detector_open = f_open;
      rep.fault_detector_short = f_short;
      rep.fault_dazzled = f_dazzle;
      return rep;
   endfunction

   function automatic req_type make_beat(input int sample, input bit pin);
      req_type beat;
      beat.adc_sample = sample[SampleWidth-1:0];
      beat.emitter_pin_high = pin;
      return beat;
   endfunction

   // Samples are biased toward the thresholds that the current state makes interesting.
   function automatic req_type random_beat();
      int sel;
      int level;
      sel = $urandom_range(0, 9);
      case (sel)
         0: level = int'(FULL_SCALE);
         1: level = 0;
         2: level = $urandom_range(0, int'(open_lvl) + 1);
         3: level = int'(dazzle_lim) + int'($urandom_range(0, 2)) - 1;
         4: level = int'(dark_rd) + int'(margin_lim) + int'($urandom_range(0, 2)) - 1;
         default: level = $urandom_range(0, int'(FULL_SCALE));
      endcase
      if (level < 0) level = 0;
      if (level > int'(FULL_SCALE)) level = int'(FULL_SCALE);
      return make_beat(int'(FULL_SCALE) - level, $urandom_range(0, 7) != 0);
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      fail_count++;
      if (fail_count <= ReportLimit)
         $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
   endtask

   task automatic send_beat(input req_type beat);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (req_stall);
      pending_reports.push_back(sensor_tick(beat));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_DAZZLE_LIMIT: dazzle_lim = value[SampleWidth-1:0];
         REG_BEAM_MARGIN:  margin_lim = value[SampleWidth-1:0];
         REG_OPEN_RUN:     run_lim = value[RunWidth-1:0];
         REG_OPEN_LEVEL:   open_lvl = value[SampleWidth-1:0];
         default: ;
      endcase
   endtask

   task automatic csr_check(input reg_index_type idx);
      logic [31:0] want;
      case (idx)
         REG_DAZZLE_LIMIT: want = 32'(dazzle_lim);
         REG_BEAM_MARGIN:  want = 32'(margin_lim);
         REG_OPEN_RUN:     want = 32'(run_lim);
         default:          want = 32'(open_lvl);
      endcase
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) note_mismatch(idx.name(), want, csr_prdata);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Upper bits of each write carry noise that the registers must drop.
   task automatic apply_settings(input int dazzle, input int margin, input int run_len,
                                 input int level);
      csr_write(REG_DAZZLE_LIMIT, {22'($urandom), dazzle[SampleWidth-1:0]});
      csr_write(REG_BEAM_MARGIN, {22'($urandom), margin[SampleWidth-1:0]});
      csr_write(REG_OPEN_RUN, {24'($urandom), run_len[RunWidth-1:0]});
      csr_write(REG_OPEN_LEVEL, {22'($urandom), level[SampleWidth-1:0]});
      csr_check(REG_DAZZLE_LIMIT);
      csr_check(REG_BEAM_MARGIN);
      csr_check(REG_OPEN_RUN);
      csr_check(REG_OPEN_LEVEL);
   endtask

   function automatic int pick_limit(input int top);
      case ($urandom_range(0, 3))
         0: return 0;
         1: return top;
         default: return $urandom_range(0, top);
      endcase
   endfunction

   task automatic test_directed_ticks();
      int samples[22] = '{512, 0, 1023, 0, 512, 0, 300, 1023, 700, 1023, 5,
                          323, 1, 923, 1022, 424, 0, 523, 1023, 1023, 256, 522};
      bit pins[22]    = '{1, 1, 0, 1, 1, 0, 1, 0, 1, 1, 0,
                          1, 1, 1, 0, 1, 0, 1, 1, 1, 0, 1};
      stall_pct = 0;
      max_gap = 0;
      foreach (samples[i]) send_beat(make_beat(samples[i], pins[i]));
      settle();
   endtask

   task automatic test_register_access();
      csr_check(REG_DAZZLE_LIMIT);
      csr_check(REG_BEAM_MARGIN);
      csr_check(REG_OPEN_RUN);
      csr_check(REG_OPEN_LEVEL);
      apply_settings($urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 255), $urandom_range(0, 1023));
      apply_settings(int'(DAZZLE_LIMIT_RESET), int'(BEAM_MARGIN_RESET),
                     int'(OPEN_RUN_RESET), int'(OPEN_LEVEL_RESET));
   endtask

   task automatic test_config_extremes();
      int settings[5][4] = '{'{0, 0, 0, 0}, '{1023, 1023, 255, 1023}, '{0, 1023, 0, 1023},
                             '{1023, 0, 255, 0}, '{500, 500, 1, 3}};
      foreach (settings[s]) begin
         apply_settings(settings[s][0], settings[s][1], settings[s][2], settings[s][3]);
         stall_pct = 10 * s;
         max_gap = s;
         repeat (60) send_beat(random_beat());
         settle();
      end
   endtask

   task automatic test_open_detector_run();
      apply_settings(500, 500, 3, 5);
      stall_pct = 20;
      max_gap = 3;
      repeat (40) begin
         if ($urandom_range(0, 7) == 0) send_beat(random_beat());
         else send_beat(make_beat(1023 - $urandom_range(0, 6), 1'($urandom_range(0, 1))));
      end
      settle();
      apply_settings(500, 500, 255, 0);
      stall_pct = 0;
      max_gap = 0;
      repeat (530) send_beat(make_beat(1023, 1'b1));
      settle();
   endtask

   task automatic test_result_backpressure();
      apply_settings(500, 500, 4, 3);
      stall_pct = 0;
      max_gap = 0;
      hold_left = 300;
      repeat (40) send_beat(random_beat());
      settle();
   endtask

   task automatic test_random_traffic();
      repeat (4) begin
         apply_settings(pick_limit(1023), pick_limit(1023), pick_limit(255), pick_limit(1023));
         stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
         max_gap = $urandom_range(0, 6);
         repeat (75) send_beat(random_beat());
         settle();
      end
   endtask

   always @(posedge clock) begin
      if (hold_left != 0) hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_left != 0) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            note_mismatch("unexpected result beat", '0, 32'(rsp_data));
         end else begin
            want = pending_reports.pop_front();
            if (rsp_data.ball_present !== want.ball_present)
               note_mismatch("ball_present", 32'(want.ball_present),
                             32'(rsp_data.ball_present));
            if (rsp_data.emitter_drive !== want.emitter_drive)
               note_mismatch("emitter_drive", 32'(want.emitter_drive),
                             32'(rsp_data.emitter_drive));
            if (rsp_data.fault_emitter_open !== want.fault_emitter_open)
               note_mismatch("fault_emitter_open", 32'(want.fault_emitter_open),
                             32'(rsp_data.fault_emitter_open));
            if (rsp_data.fault_detector_open !== want.fault_detector_open)
               note_mismatch("fault_detector_open", 32'(want.fault_detector_open),
                             32'(rsp_data.fault_detector_open));
            if (rsp_data.fault_detector_short !== want.fault_detector_short)
               note_mismatch("fault_detector_short", 32'(want.fault_detector_short),
                             32'(rsp_data.fault_detector_short));
            if (rsp_data.fault_dazzled !== want.fault_dazzled)
               note_mismatch("fault_dazzled", 32'(want.fault_dazzled),
                             32'(rsp_data.fault_dazzled));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("beam_break_ball_sensor_unit test failed");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_ticks();
      test_register_access();
      test_config_extremes();
      test_open_detector_run();
      test_result_backpressure();
      test_random_traffic();
      if (fail_count == 0 && pending_reports.size() == 0) begin
         $display("beam_break_ball_sensor_unit test passed");
      end else begin
         $display("beam_break_ball_sensor_unit test failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/bbs_pkg.sv
rtl/core/bbs_csr.sv
rtl/core/bbs_core.sv
rtl/core/beam_break_ball_sensor_unit.sv
rtl/core/bbs_checker.sv
verif/tb_beam_break_ball_sensor_unit.sv
